@@ hdl/mrt_pkg.sv @@
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared types and constants for the memory region table: default sizes,
// operation, kind and status codes, and the entry store command group.
// ----------------------------------------------------------------------------
package mrt_pkg;

  // default table depth and physical address width
  localparam int unsigned MAX_REGIONS_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF   = 32;

  // fixed field widths of the request and result
  localparam int unsigned FIELD_AW    = 32;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned INDEX_W     = 4;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned COUNT_OUT_W = 5;

  // request operation
  typedef enum logic {
    OP_REGISTER = 1'b0,
    OP_READ     = 1'b1
  } op_t;

  // region kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_AVAILABLE = 2'd0,
    KIND_RESERVED  = 2'd1,
    KIND_FAULTY    = 2'd2,
    KIND_UNUSED    = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_FULL      = 3'd2,
    ST_OVERLAP   = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  // entry store access strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

@@ hdl/memory_region_table.sv @@
// ----------------------------------------------------------------------------
// memory_region_table
// Table of physical memory regions: register requests append a region after
// zero-size, full-table and overlap checks; read requests return an entry.
// ----------------------------------------------------------------------------
//
//  channel  dir  data                                          side
//  in_      in   tdata: base, size, kind, index; tuser: op     request
//  out_     out  tdata: status, base, size, kind, count        result
//
//  a read request or a zero-size or full-table register request goes straight
//  to the done state; an accepted one scans the N stored entries, then writes;
//  an overlapping one stops at a hit: the check reads one entry per cycle.
//  reset (rst_n low, synchronous) empties the table; entries are not cleared.
//  a finished result waits in an output register while the next request is
//  taken; a request stalls in its last cycle only while that register is full.
//
module memory_region_table #(
  parameter int unsigned MAX_REGIONS = mrt_pkg::MAX_REGIONS_DEF,
  parameter int unsigned ADDR_BITS   = mrt_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] region_base, [63:32] region_size, [65:64] region_kind,
  // [69:66] entry_index, [71:70] zero
  input  logic [71:0] in_tdata,
  // [0] op
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [34:3] read_base, [66:35] read_size, [68:67] read_kind,
  // [73:69] entry_count, [79:74] zero
  output logic [79:0] out_tdata
);
  import mrt_pkg::*;

  localparam int unsigned SW     = (ADDR_BITS < FIELD_AW) ? ADDR_BITS : FIELD_AW;
  localparam int unsigned IDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_REGIONS + 1);
  localparam int unsigned DATA_W = KIND_W + 2 * SW;

  mem_cmd_t            mem_cmd;
  logic [IDX_W-1:0]    mem_wr_addr, mem_rd_addr;
  logic [DATA_W-1:0]   mem_wr_data, mem_rd_data;
  status_t             res_status;
  logic [FIELD_AW-1:0] res_base, res_size;
  logic [KIND_W-1:0]   res_kind;
  logic [COUNT_OUT_W-1:0] res_count;
  op_t                 req_op;

  // request unpacking
  assign req_op = op_t'(in_tuser);

  // sequencer
  mrt_ctrl #(
    .MAX_REGIONS (MAX_REGIONS),
    .SW          (SW),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req_op      (req_op),
    .req_base    (in_tdata[31:0]),
    .req_size    (in_tdata[63:32]),
    .req_kind    (in_tdata[65:64]),
    .req_index   (in_tdata[69:66]),
    .mem_cmd     (mem_cmd),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_status  (res_status),
    .res_base    (res_base),
    .res_size    (res_size),
    .res_kind    (res_kind),
    .res_count   (res_count)
  );

  // entry memory
  mrt_store #(
    .DEPTH  (MAX_REGIONS),
    .IDX_W  (IDX_W),
    .DATA_W (DATA_W)
  ) u_store (
    .clk     (clk),
    .cmd     (mem_cmd),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // result packing
  assign out_tdata = {6'd0, res_count, res_kind, res_size, res_base, res_status};

endmodule

@@ hdl/mrt_store.sv @@
// ----------------------------------------------------------------------------
// mrt_store
// Entry store: one synchronous memory holding kind, size and base of every
// region, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mrt_store #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned IDX_W  = 4,
  parameter int unsigned DATA_W = 66
) (
  input  logic                clk,
  input  mrt_pkg::mem_cmd_t   cmd,
  input  logic [IDX_W-1:0]    wr_addr,
  input  logic [DATA_W-1:0]   wr_data,
  input  logic [IDX_W-1:0]    rd_addr,
  output logic [DATA_W-1:0]   rd_data
);
  import mrt_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held while no read is issued
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/mrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrt_ctrl
// Request sequencer: checks a register request against stored entries one per
// cycle until a hit, appends accepted regions, serves reads, holds the result.
// ----------------------------------------------------------------------------
module mrt_ctrl #(
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned SW          = 32,
  parameter int unsigned IDX_W       = 4,
  parameter int unsigned CNT_W       = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request side
  input  logic                              req_valid,
  output logic                              req_ready,
  input  mrt_pkg::op_t                      req_op,
  input  logic [mrt_pkg::FIELD_AW-1:0]      req_base,
  input  logic [mrt_pkg::FIELD_AW-1:0]      req_size,
  input  logic [mrt_pkg::KIND_W-1:0]        req_kind,
  input  logic [mrt_pkg::INDEX_W-1:0]       req_index,
  // entry store
  output mrt_pkg::mem_cmd_t                 mem_cmd,
  output logic [IDX_W-1:0]                  mem_wr_addr,
  output logic [mrt_pkg::KIND_W+2*SW-1:0]   mem_wr_data,
  output logic [IDX_W-1:0]                  mem_rd_addr,
  input  logic [mrt_pkg::KIND_W+2*SW-1:0]   mem_rd_data,
  // result side
  output logic                              res_valid,
  input  logic                              res_ready,
  output mrt_pkg::status_t                  res_status,
  output logic [mrt_pkg::FIELD_AW-1:0]      res_base,
  output logic [mrt_pkg::FIELD_AW-1:0]      res_size,
  output logic [mrt_pkg::KIND_W-1:0]        res_kind,
  output logic [mrt_pkg::COUNT_OUT_W-1:0]   res_count
);
  import mrt_pkg::*;

  localparam int unsigned CMP_W = CNT_W + INDEX_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [SW-1:0]       base_r, base_nxt;
  logic [SW-1:0]       size_r, size_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [SW:0]         end_r, end_nxt;
  logic [IDX_W-1:0]    scan_r, scan_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  status_t             status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [FIELD_AW-1:0] out_base_r, out_base_nxt;
  logic [FIELD_AW-1:0] out_size_r, out_size_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [COUNT_OUT_W-1:0] out_count_r, out_count_nxt;

  logic [SW-1:0]       rd_base, rd_size, in_base, in_size;
  logic [KIND_W-1:0]   rd_kind, in_kind;
  logic [SW:0]         rd_end;
  logic                hit, last_entry, accept, bad_index, out_free;

  // unpack stored entry and compute its end one bit wider
  assign rd_base = mem_rd_data[SW-1:0];
  assign rd_size = mem_rd_data[2*SW-1:SW];
  assign rd_kind = mem_rd_data[KIND_W+2*SW-1:2*SW];
  assign rd_end  = {1'b0, rd_base} + {1'b0, rd_size};
  assign hit     = ({1'b0, base_r} < rd_end) && ({1'b0, rd_base} < end_r);

  // request fields cut to the address width, meaningless kind read as reserved
  assign in_base = SW'(req_base);
  assign in_size = SW'(req_size);
  assign in_kind = (req_kind == KIND_UNUSED) ? KIND_RESERVED : req_kind;

  assign req_ready  = (state_r == S_IDLE);
  assign accept     = req_valid && req_ready;
  assign bad_index  = CMP_W'(req_index) >= CMP_W'(count_r);
  assign last_entry = (CNT_W'(scan_r) + CNT_W'(1)) == count_r;
  assign out_free   = !out_valid_r || res_ready;

  // store access
  assign mem_wr_addr = IDX_W'(count_r);
  assign mem_wr_data = {kind_r, size_r, base_r};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    base_nxt       = base_r;
    size_nxt       = size_r;
    kind_nxt       = kind_r;
    end_nxt        = end_r;
    scan_nxt       = scan_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !res_ready;
    out_status_nxt = out_status_r;
    out_base_nxt   = out_base_r;
    out_size_nxt   = out_size_r;
    out_kind_nxt   = out_kind_r;
    out_count_nxt  = out_count_r;
    mem_cmd        = '0;
    mem_rd_addr    = scan_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt   = req_op;
          base_nxt = in_base;
          size_nxt = in_size;
          kind_nxt = in_kind;
          end_nxt  = {1'b0, in_base} + {1'b0, in_size};
          scan_nxt = '0;
          if (req_op == OP_READ) begin
            // read the entry now, data is there in the done state
            mem_cmd.rd_en = !bad_index;
            mem_rd_addr   = IDX_W'(req_index);
            status_nxt    = bad_index ? ST_BAD_INDEX : ST_OK;
            state_nxt     = S_DONE;
          end else if (in_size == '0) begin
            status_nxt = ST_ZERO_SIZE;
            state_nxt  = S_DONE;
          end else if (count_r >= CNT_W'(MAX_REGIONS)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else if (count_r == '0) begin
            state_nxt = S_WRITE;
          end else begin
            mem_cmd.rd_en = 1'b1;
            mem_rd_addr   = '0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // one stored entry checked per cycle
        if (hit) begin
          status_nxt = ST_OVERLAP;
          state_nxt  = S_DONE;
        end else if (last_entry) begin
          state_nxt = S_WRITE;
        end else begin
          scan_nxt      = scan_r + IDX_W'(1);
          mem_cmd.rd_en = 1'b1;
          mem_rd_addr   = scan_r + IDX_W'(1);
        end
      end
      S_WRITE: begin
        mem_cmd.wr_en = 1'b1;
        count_nxt     = count_r + CNT_W'(1);
        status_nxt    = ST_OK;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        // load the result register once it is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = COUNT_OUT_W'(count_r);
          if (op_r == OP_READ && status_r == ST_OK) begin
            out_base_nxt = FIELD_AW'(rd_base);
            out_size_nxt = FIELD_AW'(rd_size);
            out_kind_nxt = rd_kind;
          end else begin
            out_base_nxt = '0;
            out_size_nxt = '0;
            out_kind_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    base_r       <= base_nxt;
    size_r       <= size_nxt;
    kind_r       <= kind_nxt;
    end_r        <= end_nxt;
    scan_r       <= scan_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_base_r   <= out_base_nxt;
    out_size_r   <= out_size_nxt;
    out_kind_r   <= out_kind_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign res_valid  = out_valid_r;
  assign res_status = out_status_r;
  assign res_base   = out_base_r;
  assign res_size   = out_size_r;
  assign res_kind   = out_kind_r;
  assign res_count  = out_count_r;

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of memory_region_table. Each accepted request updates a
// scoreboard model of the table and queues one expected result. Every result
// is compared field by field against the oldest queued entry. Register
// requests test zero size, a full table, and overlap with stored regions,
// including enclosing and touching neighbors. Read requests use valid and bad
// indexes. Both handshakes get random gaps and long stalls.
// ----------------------------------------------------------------------------
module testbench;
  import mrt_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_REGIONS_DEF;

  // one result as the block reports it
  typedef struct packed {
    status_t     status;
    logic [31:0] base;
    logic [31:0] size;
    kind_t       kind;
    logic [4:0]  count;
  } region_result_t;

  // table model plus the queue of results still owed by the block
  class region_table_scoreboard;
    int unsigned    used;
    logic [31:0]    base_tbl[TABLE_DEPTH];
    logic [31:0]    size_tbl[TABLE_DEPTH];
    kind_t          kind_tbl[TABLE_DEPTH];
    region_result_t owed_q[$];
    int unsigned    errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // half-open interval test with ends one bit wider, so nothing wraps
    function bit collides(logic [31:0] b, logic [31:0] s);
      logic [32:0] new_end;
      logic [32:0] old_end;
      new_end = {1'b0, b} + {1'b0, s};
      for (int unsigned i = 0; i < used; i++) begin
        old_end = {1'b0, base_tbl[i]} + {1'b0, size_tbl[i]};
        if ({1'b0, b} < old_end && {1'b0, base_tbl[i]} < new_end) return 1'b1;
      end
      return 1'b0;
    endfunction

    // apply one accepted request to the model and queue its result
    function void note_request(logic op_bit, logic [71:0] data);
      op_t            op;
      logic [31:0]    b;
      logic [31:0]    s;
      kind_t          k;
      logic [3:0]     idx;
      region_result_t res;
      op  = op_t'(op_bit);
      b   = data[31:0];
      s   = data[63:32];
      k   = kind_t'(data[65:64]);
      idx = data[69:66];
      res = '0;
      res.status = ST_OK;
      res.kind   = KIND_AVAILABLE;
      if (op == OP_REGISTER) begin
        // kind three has no meaning and is kept as reserved
        if (k == KIND_UNUSED) k = KIND_RESERVED;
        if (s == '0) begin
          res.status = ST_ZERO_SIZE;
        end else if (used >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else if (collides(b, s)) begin
          res.status = ST_OVERLAP;
        end else begin
          base_tbl[used] = b;
          size_tbl[used] = s;
          kind_tbl[used] = k;
          used++;
        end
      end else begin
        if (idx >= used) begin
          res.status = ST_BAD_INDEX;
        end else begin
          res.base = base_tbl[idx];
          res.size = size_tbl[idx];
          res.kind = kind_tbl[idx];
        end
      end
      res.count = used[4:0];
      owed_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // compare one accepted result with the oldest owed one
    function void check_result(logic [79:0] data);
      region_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual %0h",
                 $time, data);
        return;
      end
      want = owed_q.pop_front();
      compare_field("status", 32'(want.status), 32'(data[2:0]));
      compare_field("read_base", want.base, data[34:3]);
      compare_field("read_size", want.size, data[66:35]);
      compare_field("read_kind", 32'(want.kind), 32'(data[68:67]));
      compare_field("entry_count", 32'(want.count), 32'(data[73:69]));
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  region_table_scoreboard sb;
  int unsigned tx_burst     = 0;
  bit          hold_off_req = 1'b0;

  memory_region_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // sample both handshakes
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // result side: random stalls, fast stretches, and long hold-offs on request
  initial begin
    int unsigned rx_stall;
    int unsigned rx_burst;
    int unsigned pick;
    rx_stall = 0;
    rx_burst = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rx_stall     = 300;
      end
      if (rx_stall != 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else if (rx_burst != 0) begin
        rx_burst--;
        out_tready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_tready <= 1'b1;
        end else if (pick < 85) begin
          rx_stall = $urandom_range(0, 2);
          out_tready <= 1'b0;
        end else if (pick < 95) begin
          rx_stall = $urandom_range(3, 12);
          out_tready <= 1'b0;
        end else if (pick < 98) begin
          rx_stall = $urandom_range(20, 50);
          out_tready <= 1'b0;
        end else begin
          rx_burst = $urandom_range(30, 80);
          out_tready <= 1'b1;
        end
      end
    end
  end

  // offer one request after a random gap and wait until it is taken
  task automatic send_request(op_t op, logic [31:0] b, logic [31:0] s,
                              logic [1:0] k, logic [3:0] idx);
    int unsigned gap;
    int unsigned pick;
    if (tx_burst != 0) begin
      tx_burst--;
      gap = 0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50)      gap = 0;
      else if (pick < 85) gap = $urandom_range(1, 3);
      else if (pick < 97) gap = $urandom_range(4, 12);
      else if (pick < 99) gap = $urandom_range(20, 60);
      else begin
        gap      = 0;
        tx_burst = $urandom_range(20, 60);
      end
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, idx, k, s, b};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // mostly register requests aimed at stored regions, so that the overlap
  // walk runs at every table depth before the table fills up
  task automatic send_random_request();
    int unsigned pick;
    int unsigned j;
    int unsigned used_now;
    logic [31:0] b;
    logic [31:0] s;
    logic [31:0] span;
    logic [1:0]  k;
    logic [3:0]  idx;
    pick     = $urandom_range(0, 999);
    used_now = sb.used;
    b        = $urandom;
    s        = $urandom;
    k        = 2'($urandom_range(0, 3));
    idx      = 4'($urandom_range(0, 15));
    j        = (used_now != 0) ? $urandom_range(0, used_now - 1) : 0;
    if (pick < 400) begin
      if (used_now != 0 && $urandom_range(0, 1) == 1) idx = 4'(j);
      send_request(OP_READ, b, s, k, idx);
    end else begin
      if (pick < 440) begin
        s = '0;
      end else if (pick < 443 || used_now == 0 && pick < 900) begin
        // fresh small region anywhere
        s = $urandom_range(1, 65536);
      end else if (pick < 446) begin
        // touching a stored region on either side
        s = $urandom_range(1, 4096);
        if ($urandom_range(0, 1) == 1) b = sb.base_tbl[j] + sb.size_tbl[j];
        else b = sb.base_tbl[j] - s;
      end else if (pick < 900) begin
        case ($urandom_range(0, 2))
          0: begin
            // starts inside
            b = sb.base_tbl[j] + ($urandom % sb.size_tbl[j]);
            s = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 4096);
          end
          1: begin
            // encloses the stored region
            span = $urandom_range(1, 4096);
            b    = sb.base_tbl[j] - span;
            s    = sb.size_tbl[j] + span + $urandom_range(0, 4096);
          end
          default: begin
            // last byte lands on the stored base
            s = $urandom_range(1, 4096);
            b = sb.base_tbl[j] - s + 32'd1;
          end
        endcase
      end
      send_request(OP_REGISTER, b, s, k, idx);
    end
  endtask

  // main stimulus
  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, zero size, address extremes, overlap shapes
    send_request(OP_READ,     32'h0,        32'h0,        KIND_AVAILABLE, 4'd0);
    send_request(OP_REGISTER, 32'h1000,     32'h0,        KIND_AVAILABLE, 4'd0);
    send_request(OP_REGISTER, 32'h0,        32'h1,        KIND_AVAILABLE, 4'd0);
    send_request(OP_REGISTER, 32'hFFFFFFFF, 32'hFFFFFFFF, KIND_FAULTY,    4'd0);
    send_request(OP_REGISTER, 32'h1000,     32'h100,      KIND_UNUSED,    4'd0);
    send_request(OP_REGISTER, 32'h800,      32'h1000,     KIND_AVAILABLE, 4'd0);
    send_request(OP_REGISTER, 32'h1080,     32'h10,       KIND_RESERVED,  4'd0);
    send_request(OP_REGISTER, 32'h10FF,     32'h1,        KIND_RESERVED,  4'd0);
    send_request(OP_REGISTER, 32'h1100,     32'h10,       KIND_FAULTY,    4'd0);
    send_request(OP_REGISTER, 32'h0FF0,     32'h10,       KIND_RESERVED,  4'd0);
    send_request(OP_REGISTER, 32'hFFFFFFFE, 32'h1,        KIND_AVAILABLE, 4'd0);
    send_request(OP_REGISTER, 32'h1,        32'hFFFFFFFF, KIND_AVAILABLE, 4'd0);
    send_request(OP_READ,     32'hFFFFFFFF, 32'hFFFFFFFF, KIND_UNUSED,    4'd2);
    send_request(OP_READ,     32'h0,        32'h0,        KIND_AVAILABLE, 4'd1);
    send_request(OP_READ,     32'h0,        32'h0,        KIND_AVAILABLE, 4'd5);
    send_request(OP_READ,     32'h0,        32'h0,        KIND_AVAILABLE, 4'd6);
    send_request(OP_READ,     32'h0,        32'h0,        KIND_AVAILABLE, 4'd15);

    repeat (500) send_random_request();

    // long result-side hold while requests keep coming back to back
    hold_off_req = 1'b1;
    tx_burst     = 30;
    repeat (30) send_random_request();

    repeat (500) send_random_request();

    // pause until idle, then fill the table and hit it while full
    in_tvalid <= 1'b0;
    wait_drained();
    while (sb.used < TABLE_DEPTH) begin
      send_request(OP_REGISTER, $urandom, $urandom_range(1, 256),
                   2'($urandom_range(0, 3)), 4'd0);
      in_tvalid <= 1'b0;
      wait_drained();
    end
    send_request(OP_REGISTER, 32'h0,        32'h0,  KIND_RESERVED,  4'd0);
    send_request(OP_REGISTER, 32'h0,        32'h1,  KIND_AVAILABLE, 4'd0);
    send_request(OP_REGISTER, 32'h7000_0000, 32'h10, KIND_FAULTY,   4'd0);
    send_request(OP_READ,     32'h0,        32'h0,  KIND_AVAILABLE, 4'd15);
    send_request(OP_READ,     32'h0,        32'h0,  KIND_AVAILABLE, 4'd0);

    repeat (300) send_random_request();
    in_tvalid <= 1'b0;

    // drain, then allow for any stray result
    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ memory_region_table.f @@
hdl/mrt_pkg.sv
hdl/mrt_store.sv
hdl/mrt_ctrl.sv
hdl/memory_region_table.sv
dv/testbench.sv
